>>> rtl/core/mfr_pkg.sv
// Shared types, constants and helpers for the frame receiver.
package mfr_pkg;

  // Default sizes
  localparam int BUFFER_BYTES_DEF = 256;
  localparam int REGION_BYTES_DEF = 256;
  localparam int REGIONS_DEF      = 4;

  // CRC-16, reflected
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam int          CRC_STEPS = 8;

  // Frame layout: address, function, length low, length high, payload, crc low, crc high
  localparam logic [7:0] FUNC_READ      = 8'h03;
  localparam int         HDR_BYTES      = 4;
  localparam int         FRAME_OVERHEAD = 6;
  localparam logic [9:0] OFFSET_LIMIT   = 10'd1000;

  // Request kinds that select a region
  localparam logic [7:0] KIND_REGION0 = 8'h01;
  localparam logic [7:0] KIND_REGION1 = 8'h03;
  localparam logic [7:0] KIND_REGION2 = 8'h04;
  localparam logic [7:0] KIND_REGION3 = 8'h07;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_REQUEST_KIND   = 2'd1;
  localparam logic [1:0] CFG_REQUEST_OFFSET = 2'd2;

  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h01;
  localparam logic [7:0] REQUEST_KIND_RST   = 8'h01;
  localparam logic [9:0] REQUEST_OFFSET_RST = 10'd0;

  // Result status codes
  localparam logic [2:0] STAT_IDLE      = 3'd0;
  localparam logic [2:0] STAT_STORED    = 3'd1;
  localparam logic [2:0] STAT_CRC_ERR   = 3'd2;
  localparam logic [2:0] STAT_OTHER_FN  = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd4;
  localparam logic [2:0] STAT_NO_REGION = 3'd5;

  // Request to the shared CRC shift unit
  typedef struct packed {
    logic        start;
    logic [15:0] seed;
    logic [7:0]  data;
  } crc_req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } region_sel_t;

  function automatic region_sel_t kind_to_region(logic [7:0] kind);
    region_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = 2'd0;
    unique case (kind)
      KIND_REGION0: sel.idx = 2'd0;
      KIND_REGION1: sel.idx = 2'd1;
      KIND_REGION2: sel.idx = 2'd2;
      KIND_REGION3: sel.idx = 2'd3;
      default:      sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

>>> rtl/core/modbus_style_frame_receiver.sv
// Reply-frame receiver: address hunt, CRC-16 check and payload copy into region memories.
//
// The block takes one beat at a time on the slave stream. A line byte (tuser low) that
// enters a frame runs through these steps before the next beat is taken: the shared
// bit-serial CRC unit folds the byte in at one bit per cycle, the sequencer updates the
// frame counters, the result is handed to the output register and the block returns to
// idle with tready high. A byte that is not the device address while hunting goes
// straight to the hand-over; a read of the region store (tuser high) first captures the
// registered read of the region memory. The byte that completes a frame with the read
// function, a good CRC, a valid request kind and an offset below the limit additionally
// runs the payload copy: each declared payload byte is read from the frame buffer in one
// state and written to the region memory in another, and a final read state closes the
// copy. The hand-over to the output register waits while that register still holds an
// unaccepted result. After reset the block clears all REGIONS*REGION_BYTES region memory
// entries (1024 with the default sizes), one entry per cycle, taking no beat meanwhile;
// configuration writes are taken at any time. Every accepted beat yields exactly one
// result beat, and the next beat is taken while a result still waits on the master side.
module modbus_style_frame_receiver #(
  parameter int BUFFER_BYTES = mfr_pkg::BUFFER_BYTES_DEF,
  parameter int REGION_BYTES = mfr_pkg::REGION_BYTES_DEF,
  parameter int REGIONS      = mfr_pkg::REGIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // rx_byte[7:0], read_region[9:8], read_offset[17:10]
  input  logic [0:0]  s_axis_tuser_i,  // cmd[0]
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // status[2:0], read_data[10:3], payload_length[18:11]
);

  localparam int AW       = $clog2(BUFFER_BYTES);          // frame buffer index and count
  localparam int RS_DEPTH = REGIONS * REGION_BYTES;
  localparam int RSW      = $clog2(RS_DEPTH);
  localparam int DSTW     = ((AW > 10) ? AW : 10) + 1;     // request offset plus copy index

  localparam logic [AW-1:0]  OVF_LIMIT = AW'(BUFFER_BYTES - 2);
  localparam logic [AW-1:0]  HDR_CNT   = AW'(mfr_pkg::HDR_BYTES);
  localparam logic [RSW-1:0] CLR_LAST  = RSW'(RS_DEPTH - 1);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_CRC     = 7'b0000100,
    ST_READ    = 7'b0001000,
    ST_COPY_RD = 7'b0010000,
    ST_COPY_WR = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [7:0] dev_addr_q, req_kind_q;
  logic [9:0] req_off_q;

  // Frame tracking
  logic [AW-1:0] cnt_q, cnt_d;
  logic [15:0]   len_q, len_d;
  logic [7:0]    len_lo_q, len_lo_d;
  logic [7:0]    func_q, func_d;
  logic [15:0]   crc_run_q, crc_run_d;
  logic [7:0]    rx_q, rx_d;
  logic          rd_ok_q, rd_ok_d;
  logic [1:0]    region_q, region_d;
  logic [AW-1:0] copy_idx_q, copy_idx_d;
  logic [RSW-1:0] clr_idx_q, clr_idx_d;

  // Pending result and output register
  logic [2:0] res_status_q, res_status_d;
  logic [7:0] res_data_q, res_data_d;
  logic [7:0] res_len_q, res_len_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] out_status_q, out_status_d;
  logic [7:0] out_data_q, out_data_d;
  logic [7:0] out_len_q, out_len_d;

  // Input fields
  logic       in_cmd;
  logic [7:0] in_rx;
  logic [1:0] in_rreg;
  logic [7:0] in_roff;
  logic       in_beat;

  // Shared CRC unit
  mfr_pkg::crc_req_t crc_req;
  logic [15:0]       crc_out;
  logic              crc_done;

  // Memories
  logic           fb_we;
  logic [AW-1:0]  fb_raddr;
  logic [7:0]     fb_rdata;
  logic           rs_we;
  logic [RSW-1:0] rs_waddr;
  logic [7:0]     rs_wdata;
  logic [RSW-1:0] rs_raddr;
  logic [7:0]     rs_rdata;

  // Sequencer helpers
  logic [AW-1:0]       cnt_next;
  logic [15:0]         len_eff;
  logic [DSTW-1:0]     copy_dst;
  logic                rd_in_range;
  logic                frame_start;
  mfr_pkg::region_sel_t kind_sel;
  logic                region_ok;

  assign in_cmd  = s_axis_tuser_i[0];
  assign in_rx   = s_axis_tdata_i[7:0];
  assign in_rreg = s_axis_tdata_i[9:8];
  assign in_roff = s_axis_tdata_i[17:10];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // A line byte enters the frame when hunting sees the address or a frame is open
  assign frame_start = in_beat && !in_cmd && ((cnt_q != '0) || (in_rx == dev_addr_q));

  // ---------------------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= mfr_pkg::DEVICE_ADDRESS_RST;
      req_kind_q <= mfr_pkg::REQUEST_KIND_RST;
      req_off_q  <= mfr_pkg::REQUEST_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mfr_pkg::CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[7:0];
        mfr_pkg::CFG_REQUEST_KIND:   req_kind_q <= cfg_data_i[7:0];
        mfr_pkg::CFG_REQUEST_OFFSET: req_off_q  <= cfg_data_i;
        default: ;  // unused index, drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // CRC unit and memories
  // ---------------------------------------------------------------------------------------
  assign crc_req.start = frame_start;
  assign crc_req.seed  = (cnt_q == '0) ? mfr_pkg::CRC_INIT : crc_run_q;
  assign crc_req.data  = in_rx;

  mfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .crc_o  (crc_out),
    .done_o (crc_done)
  );

  // Frame buffer: each frame byte lands at its position in the frame
  assign fb_we    = frame_start;
  assign fb_raddr = copy_idx_q + HDR_CNT;

  mfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_frame_buf (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (cnt_q),
    .wdata_i (in_rx),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  // Region store: cleared after reset, then written by the payload copy
  assign copy_dst    = DSTW'(req_off_q) + DSTW'(copy_idx_q);
  assign rd_in_range = (int'(in_rreg) < REGIONS) && (int'(in_roff) < REGION_BYTES);
  assign rs_raddr    = RSW'(in_rreg) * RSW'(REGION_BYTES) + RSW'(in_roff);

  always_comb begin
    rs_we    = 1'b0;
    rs_waddr = clr_idx_q;
    rs_wdata = 8'h00;
    if (state_q == ST_CLEAR) begin
      rs_we = 1'b1;
    end else if (state_q == ST_COPY_WR) begin
      // drop bytes past the region end
      rs_we    = (int'(copy_dst) < REGION_BYTES);
      rs_waddr = RSW'(region_q) * RSW'(REGION_BYTES) + RSW'(copy_dst);
      rs_wdata = fb_rdata;
    end
  end

  mfr_ram #(
    .WIDTH (8),
    .DEPTH (RS_DEPTH)
  ) u_region_store (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  assign cnt_next = cnt_q + AW'(1);
  // the length is complete once its high byte (frame byte 3) has arrived
  assign len_eff  = (cnt_next == HDR_CNT) ? {rx_q, len_lo_q} : len_q;
  assign kind_sel = mfr_pkg::kind_to_region(req_kind_q);
  assign region_ok = kind_sel.hit && (int'(kind_sel.idx) < REGIONS) &&
                     (req_off_q < mfr_pkg::OFFSET_LIMIT);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    len_lo_d     = len_lo_q;
    func_d       = func_q;
    crc_run_d    = crc_run_q;
    rx_d         = rx_q;
    rd_ok_d      = rd_ok_q;
    region_d     = region_q;
    copy_idx_d   = copy_idx_q;
    clr_idx_d    = clr_idx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_len_d    = res_len_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_len_d    = out_len_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + RSW'(1);
        if (clr_idx_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_beat) begin
          res_status_d = mfr_pkg::STAT_IDLE;
          res_data_d   = 8'h00;
          res_len_d    = 8'h00;
          rx_d         = in_rx;
          if (in_cmd) begin
            // read address goes to the region store on this edge
            rd_ok_d = rd_in_range;
            state_d = ST_READ;
          end else if (frame_start) begin
            state_d = ST_CRC;
          end else begin
            // not our address while hunting: ignore the byte
            state_d = ST_DONE;
          end
        end
      end

      ST_READ: begin
        res_data_d = rd_ok_q ? rs_rdata : 8'h00;
        state_d    = ST_DONE;
      end

      ST_CRC: begin
        if (crc_done) begin
          state_d   = ST_DONE;
          crc_run_d = crc_out;
          cnt_d     = cnt_next;
          if (cnt_q == AW'(1)) begin
            func_d = rx_q;
          end
          if (cnt_q == AW'(2)) begin
            len_lo_d = rx_q;
          end
          if (cnt_next == HDR_CNT) begin
            len_d = len_eff;
          end
          if ((cnt_q != '0) && (cnt_next > OVF_LIMIT)) begin
            // frame longer than the buffer: abort and hunt again
            res_status_d = mfr_pkg::STAT_OVERFLOW;
            res_len_d    = (len_eff > 16'd255) ? 8'hFF : len_eff[7:0];
            cnt_d        = '0;
            crc_run_d    = mfr_pkg::CRC_INIT;
          end else if ((cnt_q != '0) && (cnt_next >= HDR_CNT) &&
                       (17'(cnt_next) == (17'(len_eff) + 17'(mfr_pkg::FRAME_OVERHEAD)))) begin
            res_len_d = len_eff[7:0];
            cnt_d     = '0;
            crc_run_d = mfr_pkg::CRC_INIT;
            if (func_q != mfr_pkg::FUNC_READ) begin
              res_status_d = mfr_pkg::STAT_OTHER_FN;
            end else if (crc_out != 16'h0000) begin
              res_status_d = mfr_pkg::STAT_CRC_ERR;
            end else if (!region_ok) begin
              res_status_d = mfr_pkg::STAT_NO_REGION;
            end else begin
              res_status_d = mfr_pkg::STAT_STORED;
              region_d     = kind_sel.idx;
              copy_idx_d   = '0;
              state_d      = ST_COPY_RD;
            end
          end
        end
      end

      ST_COPY_RD: begin
        // frame buffer read is issued at fb_raddr on this edge
        if (16'(copy_idx_q) == len_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_COPY_WR;
        end
      end

      ST_COPY_WR: begin
        copy_idx_d = copy_idx_q + AW'(1);
        state_d    = ST_COPY_RD;
      end

      ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
          out_len_d    = res_len_q;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      len_q       <= '0;
      crc_run_q   <= mfr_pkg::CRC_INIT;
      clr_idx_q   <= '0;
      copy_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      crc_run_q   <= crc_run_d;
      clr_idx_q   <= clr_idx_d;
      copy_idx_q  <= copy_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_lo_q     <= len_lo_d;
    func_q       <= func_d;
    rx_q         <= rx_d;
    rd_ok_q      <= rd_ok_d;
    region_q     <= region_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_len_q    <= res_len_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_len_q    <= out_len_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_len_q, out_data_q, out_status_q};

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OVF_LIMIT)
    else $error("frame byte count past the overflow limit");

  a_store_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rs_we |-> (state_q == ST_CLEAR || state_q == ST_COPY_WR))
    else $error("region store written outside clear or copy");

  a_copy_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY_WR) |-> (16'(copy_idx_q) < len_q))
    else $error("payload copy ran past the declared length");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside the hand-over state");

  a_crc_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_done |-> (state_q == ST_CRC))
    else $error("CRC unit finished while the sequencer was not waiting");

endmodule

>>> rtl/core/mfr_ram.sv
// Generic simple dual-port RAM with registered read.
module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mfr_crc_unit.sv
// Bit-serial CRC-16 unit: folds one byte into the CRC, one bit a cycle.
module mfr_crc_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfr_pkg::crc_req_t req_i,
  output logic [15:0]       crc_o,
  output logic              done_o
);

  localparam int CW = $clog2(mfr_pkg::CRC_STEPS);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   crc_q, crc_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      crc_d  = req_i.seed ^ {8'h00, req_i.data};
    end else if (busy_q) begin
      // shift out one bit, fold the polynomial on a set LSB
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ mfr_pkg::CRC_POLY) : (crc_q >> 1);
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(mfr_pkg::CRC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign crc_o  = crc_q;
  assign done_o = done_q;

endmodule
